/* hw/rtl/psb_pkg.sv */
// ----------------------------------------------------------------------------
// psb_pkg
// Shared types, constants and the arctangent table of the scan binner.
// ----------------------------------------------------------------------------
`default_nettype none

package psb_pkg;

	localparam int BIN_COUNT    = 3600;
	localparam int COORD_BITS   = 24;
	localparam int BIN_W        = $clog2(BIN_COUNT);
	localparam int RANGE_W      = 24;
	localparam int OP_W         = 2;
	localparam int SEL_W        = 12;
	localparam int CORDIC_STEPS = 32;
	localparam int STEP_W       = 5;
	localparam int SQ_W         = 2 * COORD_BITS;
	localparam int SQRT_STEPS   = COORD_BITS;
	localparam int CW           = 64;
	localparam int SCALE_SH     = 60 - COORD_BITS;
	localparam int TURN_W       = 32;
	localparam int PROD_W       = TURN_W + BIN_W;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_W        = COORD_BITS;

	localparam logic [RANGE_W-1:0] RANGE_TOP = {RANGE_W{1'b1}};
	localparam logic signed [CFG_W-1:0] Z_MIN_RST = CFG_W'(0);
	localparam logic signed [CFG_W-1:0] Z_MAX_RST = CFG_W'(410);

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_CLEAR  = 2'd2
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_Z_MIN = 1'b0,
		REG_Z_MAX = 1'b1
	} reg_idx_t;

	typedef logic [BIN_W-1:0]             bin_t;
	typedef logic [RANGE_W-1:0]           range_t;
	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   done;
		logic   hit;
		bin_t   idx;
		range_t range;
	} geom_res_t;

	function automatic logic [TURN_W-1:0] atan_turn(input logic [STEP_W-1:0] i);
		logic [TURN_W-1:0] v;
		unique case (i)
			5'd0:  v = 32'd536870912;
			5'd1:  v = 32'd316933406;
			5'd2:  v = 32'd167458907;
			5'd3:  v = 32'd85004756;
			5'd4:  v = 32'd42667331;
			5'd5:  v = 32'd21354465;
			5'd6:  v = 32'd10679838;
			5'd7:  v = 32'd5340245;
			5'd8:  v = 32'd2670163;
			5'd9:  v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			5'd30: v = 32'd1;
			5'd31: v = 32'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/psb_if.sv */
// ----------------------------------------------------------------------------
// psb_if
// Valid/ready channels for point beats and bin read result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface psb_point_if;
	logic                                valid;
	logic                                ready;
	logic [psb_pkg::OP_W-1:0]            op;
	logic signed [psb_pkg::COORD_BITS-1:0] px;
	logic signed [psb_pkg::COORD_BITS-1:0] py;
	logic signed [psb_pkg::COORD_BITS-1:0] pz;
	logic [psb_pkg::SEL_W-1:0]           read_bin;

	modport source (output valid, op, px, py, pz, read_bin, input ready);
	modport sink   (input valid, op, px, py, pz, read_bin, output ready);
endinterface

interface psb_result_if;
	logic                         valid;
	logic                         ready;
	logic [psb_pkg::SEL_W-1:0]    bin_number;
	logic [psb_pkg::RANGE_W-1:0]  min_range;

	modport source (output valid, bin_number, min_range, input ready);
	modport sink   (input valid, bin_number, min_range, output ready);
endinterface

`default_nettype wire

/* hw/rtl/psb_store.sv */
// ----------------------------------------------------------------------------
// psb_store
// Bin range memory: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_store (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire psb_pkg::bin_t   waddr,
	input  wire psb_pkg::range_t wdata,
	input  wire logic            re,
	input  wire psb_pkg::bin_t   raddr,
	output psb_pkg::range_t      rdata
);

	psb_pkg::range_t mem [psb_pkg::BIN_COUNT];
	psb_pkg::range_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/psb_geom.sv */
// ----------------------------------------------------------------------------
// psb_geom
// Iterative range and angle unit: squares, then a bit-pair square root and
// CORDIC vectoring sharing one step counter; the turn value is scaled to a bin.
// ----------------------------------------------------------------------------
`default_nettype none

module psb_geom (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire psb_pkg::coord_t     x,
	input  wire psb_pkg::coord_t     y,
	output psb_pkg::geom_res_t       res
);

	typedef enum logic [4:0] {
		G_IDLE = 5'b00001,
		G_SQX  = 5'b00010,
		G_SQY  = 5'b00100,
		G_ITER = 5'b01000,
		G_BIN  = 5'b10000
	} gstate_t;

	gstate_t                                    state_q;
	logic [psb_pkg::STEP_W-1:0]                 cnt_q;
	psb_pkg::coord_t                            x_q;
	psb_pkg::coord_t                            y_q;
	logic [psb_pkg::SQ_W-1:0]                   sum_q;
	logic [psb_pkg::SQ_W-1:0]                   n_q;
	logic [psb_pkg::SQ_W-1:0]                   root_q;
	logic [psb_pkg::SQ_W-2:0]                   bit_q;
	logic signed [psb_pkg::CW-1:0]              cx_q;
	logic signed [psb_pkg::CW-1:0]              cy_q;
	logic [psb_pkg::TURN_W-1:0]                 cz_q;
	logic                                       done_q;
	logic                                       hit_q;
	psb_pkg::bin_t                              idx_q;
	psb_pkg::range_t                            range_q;

	logic [psb_pkg::COORD_BITS-1:0] ax;
	logic [psb_pkg::COORD_BITS-1:0] ay;
	logic [psb_pkg::SQ_W-1:0]       trial;
	logic signed [psb_pkg::CW-1:0]  dx;
	logic signed [psb_pkg::CW-1:0]  dy;
	logic signed [psb_pkg::CW-1:0]  xs;
	logic signed [psb_pkg::CW-1:0]  ys;
	logic [psb_pkg::TURN_W-1:0]     u;
	logic [psb_pkg::PROD_W-1:0]     prod;
	psb_pkg::bin_t                  idx;

	always_comb begin
		ax    = x_q[psb_pkg::COORD_BITS-1] ? (~x_q + 1'b1) : x_q;
		ay    = y_q[psb_pkg::COORD_BITS-1] ? (~y_q + 1'b1) : y_q;
		trial = root_q + {1'b0, bit_q};
		dx    = cy_q >>> cnt_q;
		dy    = cx_q >>> cnt_q;
		xs    = psb_pkg::CW'(x_q) <<< psb_pkg::SCALE_SH;
		ys    = psb_pkg::CW'(y_q) <<< psb_pkg::SCALE_SH;
		u     = cz_q + {1'b1, {(psb_pkg::TURN_W-1){1'b0}}};
		prod  = psb_pkg::PROD_W'(u) * psb_pkg::PROD_W'(psb_pkg::BIN_COUNT);
		idx   = prod[psb_pkg::PROD_W-1:psb_pkg::TURN_W];
		if (y_q == '0) begin
			idx = x_q[psb_pkg::COORD_BITS-1] ? psb_pkg::BIN_W'(psb_pkg::BIN_COUNT - 1)
				: psb_pkg::BIN_W'(psb_pkg::BIN_COUNT / 2);
		end
		if (int'(idx) >= psb_pkg::BIN_COUNT) begin
			idx = psb_pkg::BIN_W'(psb_pkg::BIN_COUNT - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == G_BIN);
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						state_q <= G_SQX;
					end
				end
				G_SQX: begin
					state_q <= G_SQY;
				end
				G_SQY: begin
					cnt_q   <= '0;
					state_q <= G_ITER;
				end
				G_ITER: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == psb_pkg::STEP_W'(psb_pkg::CORDIC_STEPS - 1)) begin
						state_q <= G_BIN;
					end
				end
				G_BIN: begin
					state_q <= G_IDLE;
				end
				default: state_q <= G_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			G_IDLE: begin
				if (start) begin
					x_q <= x;
					y_q <= y;
				end
			end
			G_SQX: begin
				sum_q <= psb_pkg::SQ_W'(ax) * psb_pkg::SQ_W'(ax);
				if (x_q[psb_pkg::COORD_BITS-1]) begin
					cx_q <= -xs;
					cy_q <= -ys;
					cz_q <= {1'b1, {(psb_pkg::TURN_W-1){1'b0}}};
				end else begin
					cx_q <= xs;
					cy_q <= ys;
					cz_q <= '0;
				end
			end
			G_SQY: begin
				n_q    <= sum_q + psb_pkg::SQ_W'(ay) * psb_pkg::SQ_W'(ay);
				root_q <= '0;
				bit_q  <= {1'b1, {(psb_pkg::SQ_W-2){1'b0}}};
			end
			G_ITER: begin
				if (cy_q >= 0) begin
					cx_q <= cx_q + dx;
					cy_q <= cy_q - dy;
					cz_q <= cz_q + psb_pkg::atan_turn(cnt_q);
				end else begin
					cx_q <= cx_q - dx;
					cy_q <= cy_q + dy;
					cz_q <= cz_q - psb_pkg::atan_turn(cnt_q);
				end
				if (int'(cnt_q) < psb_pkg::SQRT_STEPS) begin
					if (n_q >= trial) begin
						n_q    <= n_q - trial;
						root_q <= (root_q >> 1) + {1'b0, bit_q};
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
			G_BIN: begin
				hit_q   <= (root_q != '0);
				idx_q   <= idx;
				range_q <= (root_q > psb_pkg::SQ_W'(psb_pkg::RANGE_TOP))
					? psb_pkg::RANGE_TOP : root_q[psb_pkg::RANGE_W-1:0];
			end
			default: ;
		endcase
	end

	assign res = '{done: done_q, hit: hit_q, idx: idx_q, range: range_q};

endmodule

`default_nettype wire

/* hw/rtl/point_scan_min_range_binner.sv */
// Insert: squares, the 32-step CORDIC loop that shares its counter with the root
// and the bin stage run first, then a hit updates the bin before the next beat.
// Read: result register loaded 1 cycle after accept when it is free.
// Clear: all 3600 bins are zeroed, one bin per cycle through the single write port.
// After reset the same clearing pass runs before the first beat.
// One item is in flight at a time; configuration writes are taken any time.
// ----------------------------------------------------------------------------
// point_scan_min_range_binner
// Bins planar points by angle and keeps the minimum range of each bin.
// ----------------------------------------------------------------------------
`default_nettype none

module point_scan_min_range_binner (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	psb_point_if.sink                          points,
	psb_result_if.source                       results,
	input  wire logic                          wr_en,
	input  wire logic [psb_pkg::CFG_IDX_W-1:0] wr_index,
	input  wire logic [psb_pkg::CFG_W-1:0]     wr_data
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_GEOM  = 5'b00100,
		S_UPD   = 5'b01000,
		S_RDATA = 5'b10000
	} state_t;

	state_t                          state_q;
	psb_pkg::bin_t                   clr_q;
	psb_pkg::bin_t                   upd_idx_q;
	psb_pkg::range_t                 upd_rng_q;
	logic [psb_pkg::SEL_W-1:0]       sel_q;
	logic                            oob_q;
	logic signed [psb_pkg::CFG_W-1:0] z_min_q;
	logic signed [psb_pkg::CFG_W-1:0] z_max_q;
	logic                            out_valid_q;
	logic [psb_pkg::SEL_W-1:0]       out_bin_q;
	psb_pkg::range_t                 out_rng_q;

	psb_pkg::geom_res_t gres;
	logic               accept;
	logic               keep;
	logic               geom_start;
	logic               re;
	psb_pkg::bin_t      raddr;
	logic               we;
	psb_pkg::bin_t      waddr;
	psb_pkg::range_t    wdata;
	psb_pkg::range_t    rdata;
	logic               out_free;

	assign points.ready = (state_q == S_IDLE);
	assign accept       = points.valid && points.ready;
	assign keep         = (points.pz >= z_min_q) && (points.pz <= z_max_q);
	assign geom_start   = accept && (points.op == psb_pkg::OP_INSERT) && keep;
	assign out_free     = !out_valid_q || results.ready;

	always_comb begin
		re    = 1'b0;
		raddr = gres.idx;
		if (accept && (points.op == psb_pkg::OP_READ)) begin
			re    = (int'(points.read_bin) < psb_pkg::BIN_COUNT);
			raddr = points.read_bin[psb_pkg::BIN_W-1:0];
		end else if ((state_q == S_GEOM) && gres.done && gres.hit) begin
			re = 1'b1;
		end
		we    = 1'b0;
		waddr = upd_idx_q;
		wdata = upd_rng_q;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (state_q == S_UPD) begin
			we = (rdata == '0) || (upd_rng_q < rdata);
		end
	end

	psb_geom u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (geom_start),
		.x      (points.px),
		.y      (points.py),
		.res    (gres)
	);

	psb_store u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			z_min_q     <= psb_pkg::Z_MIN_RST;
			z_max_q     <= psb_pkg::Z_MAX_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					psb_pkg::REG_Z_MIN: z_min_q <= wr_data;
					psb_pkg::REG_Z_MAX: z_max_q <= wr_data;
					default: ;
				endcase
			end
			if ((state_q == S_RDATA) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == psb_pkg::BIN_W'(psb_pkg::BIN_COUNT - 1)) begin
						clr_q   <= '0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						unique case (points.op)
							psb_pkg::OP_INSERT: if (keep) state_q <= S_GEOM;
							psb_pkg::OP_READ:   state_q <= S_RDATA;
							psb_pkg::OP_CLEAR:  state_q <= S_CLEAR;
							default: ;
						endcase
					end
				end
				S_GEOM: begin
					if (gres.done) begin
						state_q <= gres.hit ? S_UPD : S_IDLE;
					end
				end
				S_UPD: begin
					state_q <= S_IDLE;
				end
				S_RDATA: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sel_q <= points.read_bin;
			oob_q <= !(int'(points.read_bin) < psb_pkg::BIN_COUNT);
		end
		if ((state_q == S_GEOM) && gres.done) begin
			upd_idx_q <= gres.idx;
			upd_rng_q <= gres.range;
		end
		if ((state_q == S_RDATA) && out_free) begin
			out_bin_q <= sel_q;
			out_rng_q <= oob_q ? '0 : rdata;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.bin_number = out_bin_q;
	assign results.min_range  = out_rng_q;

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> state_q == S_IDLE)
		else $error("beat accepted outside idle");
	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_CLEAR || state_q == S_UPD))
		else $error("memory written outside clear or update");
	a_geom_done: assert property (@(posedge clk) disable iff (!arst_n)
		gres.done |-> state_q == S_GEOM)
		else $error("geometry result with no insert pending");
	a_read_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD) |-> $past(re))
		else $error("bin update without a memory read");

endmodule

`default_nettype wire
